### hw/rtl/hic_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header checker package
// Shared types and constants for the IPv4 header checker blocks.
// ----------------------------------------------------------------------------
package hic_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned CODE_W      = 3;
    localparam int unsigned IDX_W       = 5;
    localparam int unsigned SUM_W       = 20;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W  = 56;

    localparam logic [IDX_W-1:0]  HDR_BYTES    = 5'd20;
    localparam logic [BYTE_W-1:0] VHL_EXPECTED = 8'h45;
    localparam logic [LEN_W-1:0]  SUM_GOOD     = 16'hFFFF;
    localparam logic [BYTE_W-1:0] PROTO_ICMP   = 8'd1;
    localparam logic [BYTE_W-1:0] PROTO_TCP    = 8'd6;

    // Header byte positions.
    localparam logic [IDX_W-1:0] POS_VHL      = 5'd0;
    localparam logic [IDX_W-1:0] POS_LEN_HI   = 5'd2;
    localparam logic [IDX_W-1:0] POS_LEN_LO   = 5'd3;
    localparam logic [IDX_W-1:0] POS_PROTO    = 5'd9;
    localparam logic [IDX_W-1:0] POS_SRC_0    = 5'd12;
    localparam logic [IDX_W-1:0] POS_SRC_1    = 5'd13;
    localparam logic [IDX_W-1:0] POS_SRC_2    = 5'd14;
    localparam logic [IDX_W-1:0] POS_SRC_3    = 5'd15;
    localparam logic [IDX_W-1:0] POS_DST_0    = 5'd16;
    localparam logic [IDX_W-1:0] POS_DST_1    = 5'd17;
    localparam logic [IDX_W-1:0] POS_DST_2    = 5'd18;
    localparam logic [IDX_W-1:0] POS_DST_3    = 5'd19;

    // Verdict codes.
    localparam logic [CODE_W-1:0] ERR_OK       = 3'd0;
    localparam logic [CODE_W-1:0] ERR_VERSION  = 3'd1;
    localparam logic [CODE_W-1:0] ERR_LENGTH   = 3'd2;
    localparam logic [CODE_W-1:0] ERR_PROTOCOL = 3'd3;
    localparam logic [CODE_W-1:0] ERR_DEST     = 3'd4;
    localparam logic [CODE_W-1:0] ERR_CHECKSUM = 3'd5;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL_LEN = 1'd1;

    localparam logic [ADDR_W-1:0] LOCAL_ADDRESS_RST = 32'hC0A80302;
    localparam logic [LEN_W-1:0]  MAX_TOTAL_LEN_RST = 16'd255;

    typedef struct packed {
        logic [ADDR_W-1:0] local_address;
        logic [LEN_W-1:0]  max_total_length;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] error_code;
        logic [ADDR_W-1:0] source_address;
        logic [BYTE_W-1:0] protocol;
        logic [LEN_W-1:0]  total_length;
    } t_verdict;

endpackage

### hw/rtl/hic_cfg_regs.sv
// ----------------------------------------------------------------------------
// IPv4 header checker configuration registers
// Holds the local address and the total length limit, written by index.
// ----------------------------------------------------------------------------
module hic_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hic_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hic_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output hic_pkg::t_cfg                 o_cfg
);
    import hic_pkg::*;

    logic [ADDR_W-1:0] r_local_address;
    logic [LEN_W-1:0]  r_max_total_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address    <= LOCAL_ADDRESS_RST;
            r_max_total_length <= MAX_TOTAL_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOCAL_ADDRESS: r_local_address    <= i_cfg_data[ADDR_W-1:0];
                REG_MAX_TOTAL_LEN: r_max_total_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.local_address    = r_local_address;
    assign o_cfg.max_total_length = r_max_total_length;

endmodule

### hw/rtl/hic_parser.sv
// ----------------------------------------------------------------------------
// IPv4 header checker parser
// Registers each incoming byte, then updates the header state and decides
// whether this byte ends the header with a verdict.
// ----------------------------------------------------------------------------
module hic_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hic_pkg::t_cfg              i_cfg,
    input  logic                       i_in_valid,
    input  logic [hic_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                       i_in_start,
    output logic                       o_in_ready,
    input  logic                       i_out_free,
    output logic                       o_res_valid,
    output hic_pkg::t_verdict          o_res
);
    import hic_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;

    logic              r_active;
    logic [IDX_W-1:0]  r_byte_index;
    logic [SUM_W-1:0]  r_sum;
    logic [LEN_W-1:0]  r_length;
    logic [BYTE_W-1:0] r_protocol;
    logic [ADDR_W-1:0] r_source;

    logic              n_active;
    logic [IDX_W-1:0]  n_byte_index;
    logic [SUM_W-1:0]  n_sum;
    logic [LEN_W-1:0]  n_length;
    logic [BYTE_W-1:0] n_protocol;
    logic [ADDR_W-1:0] n_source;

    logic              advance;
    logic              active;
    logic [IDX_W-1:0]  idx;
    logic [SUM_W-1:0]  sum_base;
    logic [LEN_W-1:0]  len_base;
    logic [BYTE_W-1:0] proto_base;
    logic [ADDR_W-1:0] src_base;
    logic [BYTE_W-1:0] dst_byte;
    logic [SUM_W-1:0]  sum_add;
    logic [LEN_W:0]    fold_a;
    logic [LEN_W-1:0]  fold_b;
    logic              field_err;
    logic [CODE_W-1:0] field_code;
    logic              done;

    assign advance    = r_in_valid && i_out_free;
    assign o_in_ready = !r_in_valid || i_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_in_byte;
            r_in_start <= i_in_start;
        end
    end

    // A frame start restarts the parse from clean state in the same cycle.
    assign active     = r_in_start || r_active;
    assign idx        = r_in_start ? '0 : r_byte_index;
    assign sum_base   = r_in_start ? '0 : r_sum;
    assign len_base   = r_in_start ? '0 : r_length;
    assign proto_base = r_in_start ? '0 : r_protocol;
    assign src_base   = r_in_start ? '0 : r_source;

    always_comb begin
        case (idx[1:0])
            2'd0:    dst_byte = i_cfg.local_address[31:24];
            2'd1:    dst_byte = i_cfg.local_address[23:16];
            2'd2:    dst_byte = i_cfg.local_address[15:8];
            default: dst_byte = i_cfg.local_address[7:0];
        endcase
    end

    always_comb begin
        n_length   = len_base;
        n_protocol = proto_base;
        n_source   = src_base;
        field_err  = 1'b0;
        field_code = ERR_OK;
        case (idx)
            POS_VHL: begin
                if (r_in_byte != VHL_EXPECTED) begin
                    field_err  = 1'b1;
                    field_code = ERR_VERSION;
                end
            end
            POS_LEN_HI: n_length = {r_in_byte, 8'h00};
            POS_LEN_LO: begin
                n_length = len_base | {8'h00, r_in_byte};
                if (n_length > i_cfg.max_total_length) begin
                    field_err  = 1'b1;
                    field_code = ERR_LENGTH;
                end
            end
            POS_PROTO: begin
                n_protocol = r_in_byte;
                if (r_in_byte != PROTO_ICMP && r_in_byte != PROTO_TCP) begin
                    field_err  = 1'b1;
                    field_code = ERR_PROTOCOL;
                end
            end
            POS_SRC_0, POS_SRC_1, POS_SRC_2, POS_SRC_3: begin
                n_source = {src_base[ADDR_W-BYTE_W-1:0], r_in_byte};
            end
            POS_DST_0, POS_DST_1, POS_DST_2, POS_DST_3: begin
                if (dst_byte != r_in_byte) begin
                    field_err  = 1'b1;
                    field_code = ERR_DEST;
                end
            end
            default: ;
        endcase
    end

    // Even positions carry the high byte of a big-endian word.
    assign sum_add      = idx[0] ? {12'd0, r_in_byte} : {4'd0, r_in_byte, 8'd0};
    assign n_sum        = sum_base + sum_add;
    assign n_byte_index = idx + 5'd1;
    assign done         = (n_byte_index >= HDR_BYTES);

    assign fold_a = {1'b0, n_sum[LEN_W-1:0]} + {13'd0, n_sum[SUM_W-1:LEN_W]};
    assign fold_b = fold_a[LEN_W-1:0] + {15'd0, fold_a[LEN_W]};

    assign o_res_valid           = advance && active && (field_err || done);
    assign o_res.error_code      = field_err ? field_code :
                                   ((fold_b != SUM_GOOD) ? ERR_CHECKSUM : ERR_OK);
    assign o_res.total_length    = n_length;
    assign o_res.protocol        = n_protocol;
    assign o_res.source_address  = n_source;

    assign n_active = active && !(field_err || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_byte_index <= '0;
            r_sum        <= '0;
            r_length     <= '0;
            r_protocol   <= '0;
            r_source     <= '0;
        end else if (advance && active) begin
            r_active     <= n_active;
            r_byte_index <= n_byte_index;
            r_sum        <= n_sum;
            r_length     <= n_length;
            r_protocol   <= n_protocol;
            r_source     <= n_source;
        end
    end

    a_verdict_ends_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !r_active)
        else $error("parse still active after a verdict");

    a_index_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_byte_index < HDR_BYTES))
        else $error("active parse beyond the header");

    a_ok_protocol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error_code == ERR_OK) |->
            (o_res.protocol == PROTO_ICMP || o_res.protocol == PROTO_TCP))
        else $error("accepted header with a bad protocol");

endmodule

### hw/rtl/hic_out_reg.sv
// ----------------------------------------------------------------------------
// IPv4 header checker result register
// Holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module hic_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  hic_pkg::t_verdict i_res,
    output logic              o_free,
    output logic              o_tvalid,
    input  logic              i_tready,
    output hic_pkg::t_verdict o_res
);
    import hic_pkg::*;

    logic     r_valid;
    t_verdict r_res;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_res    = r_res;

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_free && i_res_valid) |=> o_tvalid)
        else $error("verdict lost in the result register");

endmodule

### hw/rtl/ipv4_header_checker_unit.sv
// ----------------------------------------------------------------------------
// IPv4 header checker
// Parses a 20-byte IPv4 header one byte per item and reports one verdict.
// ----------------------------------------------------------------------------
// The block takes one packet byte per clock cycle, flagged in tuser when it is
// the first byte of a frame, and gives one verdict per frame: at the first
// bad field (version/IHL, total length, protocol, destination) or after the
// twentieth byte with the checksum result. Each byte passes an input register
// and one stage of field and checksum logic into a result register, and a
// byte is accepted in every cycle while the result register is free or
// being read. Bytes after a verdict are dropped until the next frame start.
module ipv4_header_checker_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hic_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hic_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                      s_axis_tuser,  // [0] frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] total_length, [23:16] protocol, [55:24] source_address
    output logic [hic_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [hic_pkg::CODE_W-1:0]      m_axis_tuser   // [2:0] error_code
);
    import hic_pkg::*;

    t_cfg     cfg;
    t_verdict res;
    t_verdict out_res;
    logic     res_valid;
    logic     out_free;

    hic_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hic_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .i_in_byte   (s_axis_tdata),
        .i_in_start  (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hic_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {out_res.source_address, out_res.protocol, out_res.total_length};
    assign m_axis_tuser = out_res.error_code;

endmodule
